### rtl/tpd_pkg.sv
`default_nettype none
package tpd_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int OUT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_A_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C_Y = 3'd5;

	localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

	typedef logic [OUT_W-1:0] dist_t;

endpackage
`default_nettype wire

### rtl/tpd_edge.sv
`default_nettype none
module tpd_edge #(
	parameter int COORD_BITS = 8,
	parameter int FRAC_BITS = 7
) (
	input  wire logic                                  clk,
	input  wire logic [COORD_BITS-1:0]                 px,
	input  wire logic [COORD_BITS-1:0]                 py,
	input  wire logic [COORD_BITS-1:0]                 x1,
	input  wire logic [COORD_BITS-1:0]                 y1,
	input  wire logic [COORD_BITS-1:0]                 x2,
	input  wire logic [COORD_BITS-1:0]                 y2,
	output logic      [2*COORD_BITS+2*FRAC_BITS:0]     scaled
);
	localparam int C = COORD_BITS;
	localparam int SW = 2*C+1+2*FRAC_BITS;
	localparam int LW = 2*C+1;
	localparam int NW = 4*C+2+2*FRAC_BITS;

	// stage 1: differences
	logic signed [C:0] dx_s1, dy_s1, ux_s1, uy_s1, vx_s1, vy_s1;
	always_ff @(posedge clk) begin
		dx_s1 <= $signed({1'b0, x2}) - $signed({1'b0, x1});
		dy_s1 <= $signed({1'b0, y2}) - $signed({1'b0, y1});
		ux_s1 <= $signed({1'b0, px}) - $signed({1'b0, x1});
		uy_s1 <= $signed({1'b0, py}) - $signed({1'b0, y1});
		vx_s1 <= $signed({1'b0, px}) - $signed({1'b0, x2});
		vy_s1 <= $signed({1'b0, py}) - $signed({1'b0, y2});
	end

	// stage 2: products
	logic signed [2*C+2:0] len_w, dot_w, cr_w, du_w, dv_w;
	logic        [LW-1:0]  len_s2, du_s2, dv_s2;
	logic signed [2*C+2:0] dot_s2, cr_s2;
	always_comb begin
		len_w = dx_s1*dx_s1 + dy_s1*dy_s1;
		dot_w = ux_s1*dx_s1 + uy_s1*dy_s1;
		cr_w  = ux_s1*dy_s1 - uy_s1*dx_s1;
		du_w  = ux_s1*ux_s1 + uy_s1*uy_s1;
		dv_w  = vx_s1*vx_s1 + vy_s1*vy_s1;
	end
	always_ff @(posedge clk) begin
		len_s2 <= len_w[LW-1:0];
		du_s2  <= du_w[LW-1:0];
		dv_s2  <= dv_w[LW-1:0];
		dot_s2 <= dot_w;
		cr_s2  <= cr_w;
	end

	// stage 3: classify, square the cross product
	logic signed [2*C+2:0] acr_w, len_sx;
	logic        [LW-1:0]  acr_u;
	logic        [NW-1:0]  num_w;
	logic                  inner_w;
	always_comb begin
		acr_w   = (cr_s2 < 0) ? -cr_s2 : cr_s2;
		acr_u   = acr_w[LW-1:0];
		num_w   = NW'(acr_u*acr_u) << (2*FRAC_BITS);
		len_sx  = $signed({2'b00, len_s2});
		inner_w = (len_s2 != '0) && (dot_s2 > 0) && (dot_s2 < len_sx);
	end

	logic [LW-1:0] rem_s  [0:SW];
	logic [SW-1:0] lo_s   [0:SW];
	logic [SW-1:0] quo_s  [0:SW];
	logic [LW-1:0] len_s  [0:SW];
	logic [LW-1:0] vert_s [0:SW];
	logic          in_s   [0:SW];

	always_ff @(posedge clk) begin
		rem_s[0]  <= num_w[NW-1:SW];
		lo_s[0]   <= num_w[SW-1:0];
		quo_s[0]  <= '0;
		len_s[0]  <= len_s2;
		vert_s[0] <= (len_s2 == '0 || dot_s2 <= 0) ? du_s2 : dv_s2;
		in_s[0]   <= inner_w;
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 1; k <= SW; k++) begin : g_div
		logic [LW:0] t_w, d_w;
		logic        ge_w;
		always_comb begin
			t_w  = {rem_s[k-1], lo_s[k-1][SW-1]};
			ge_w = (t_w >= {1'b0, len_s[k-1]});
			d_w  = t_w - {1'b0, len_s[k-1]};
		end
		always_ff @(posedge clk) begin
			rem_s[k]  <= ge_w ? d_w[LW-1:0] : t_w[LW-1:0];
			lo_s[k]   <= lo_s[k-1] << 1;
			quo_s[k]  <= {quo_s[k-1][SW-2:0], ge_w};
			len_s[k]  <= len_s[k-1];
			vert_s[k] <= vert_s[k-1];
			in_s[k]   <= in_s[k-1];
		end
	end

	assign scaled = in_s[SW] ? quo_s[SW] : (SW'(vert_s[SW]) << (2*FRAC_BITS));

endmodule
`default_nettype wire

### rtl/tpd_isqrt.sv
`default_nettype none
module tpd_isqrt #(
	parameter int IN_W = 31
) (
	input  wire logic                clk,
	input  wire logic [IN_W-1:0]     value,
	output logic      [(IN_W+1)/2-1:0] root
);
	localparam int NS = (IN_W+1)/2;
	localparam int EW = 2*NS;
	localparam int RMW = NS+2;

	logic [RMW-1:0] rem_s  [1:NS];
	logic [NS-1:0]  root_s [1:NS];
	logic [EW-1:0]  lo_s   [1:NS];

	logic [EW-1:0]  pad_w;
	logic [RMW-1:0] t0_w;
	logic           ge0_w;
	always_comb begin
		pad_w = EW'(value);
		t0_w  = RMW'(pad_w[EW-1:EW-2]);
		ge0_w = (t0_w >= RMW'(1));
	end
	always_ff @(posedge clk) begin
		rem_s[1]  <= ge0_w ? t0_w - RMW'(1) : t0_w;
		root_s[1] <= NS'(ge0_w);
		lo_s[1]   <= pad_w << 2;
	end

	// one result bit per stage
	for (genvar k = 2; k <= NS; k++) begin : g_sq
		logic [RMW-1:0] t_w, trial_w;
		logic           ge_w;
		always_comb begin
			t_w     = {rem_s[k-1][RMW-3:0], lo_s[k-1][EW-1:EW-2]};
			trial_w = {root_s[k-1], 2'b01};
			ge_w    = (t_w >= trial_w);
		end
		always_ff @(posedge clk) begin
			rem_s[k]  <= ge_w ? t_w - trial_w : t_w;
			root_s[k] <= {root_s[k-1][NS-2:0], ge_w};
			lo_s[k]   <= lo_s[k-1] << 2;
		end
	end

	assign root = root_s[NS];

endmodule
`default_nettype wire

### rtl/triangle_perimeter_distance.sv
`default_nettype none
// distance from a point to the perimeter of a triangle
//
// the six vertex coordinates are written through the config channel
// (cfg_valid/cfg_ready, cfg_index 0..5 = a.x a.y b.x b.y c.x c.y, cfg_data);
// cfg_ready is always high and indices above 5 are dropped. write them only
// while no point is in flight.
// a point beat is taken at each edge where start is high; busy stays low, so
// one point can enter every clock cycle. the result appears on distance_q for
// one cycle with done high, once the point has passed the edge stages, the
// nearest-edge register, the square root and the output register. the depth
// is set by the edge divider, one quotient bit per stage, followed by the
// square root, one result bit per stage.
// the receiver cannot hold results off; nothing waits, nothing is dropped.
// reset clears the vertex registers to zero and empties the pipeline.
module triangle_perimeter_distance
	import tpd_pkg::*;
#(
	parameter int COORD_BITS = 8,
	parameter int FRAC_BITS = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [COORD_BITS-1:0] point_x,
	input  wire logic [COORD_BITS-1:0] point_y,
	output logic                       done,
	output dist_t                      distance_q,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [COORD_BITS-1:0] cfg_data
);
	localparam int C = COORD_BITS;
	localparam int SW = 2*C+1+2*FRAC_BITS;
	localparam int NS = (SW+1)/2;
	localparam int LAT = 3 + SW + 1 + NS + 1;

	logic [C-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_A_X: ax_q <= cfg_data;
				REG_A_Y: ay_q <= cfg_data;
				REG_B_X: bx_q <= cfg_data;
				REG_B_Y: by_q <= cfg_data;
				REG_C_X: cx_q <= cfg_data;
				REG_C_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [SW-1:0] e_ab, e_bc, e_ca;

	tpd_edge #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_ab (
		.clk(clk), .px(point_x), .py(point_y),
		.x1(ax_q), .y1(ay_q), .x2(bx_q), .y2(by_q), .scaled(e_ab)
	);
	tpd_edge #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_bc (
		.clk(clk), .px(point_x), .py(point_y),
		.x1(bx_q), .y1(by_q), .x2(cx_q), .y2(cy_q), .scaled(e_bc)
	);
	tpd_edge #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_ca (
		.clk(clk), .px(point_x), .py(point_y),
		.x1(cx_q), .y1(cy_q), .x2(ax_q), .y2(ay_q), .scaled(e_ca)
	);

	// nearest edge on the squared value
	logic [SW-1:0] m_w, min_s;
	always_comb begin
		m_w = (e_bc < e_ab) ? e_bc : e_ab;
		if (e_ca < m_w) begin
			m_w = e_ca;
		end
	end
	always_ff @(posedge clk) begin
		min_s <= m_w;
	end

	logic [NS-1:0] root_w;
	tpd_isqrt #(.IN_W(SW)) u_sqrt (
		.clk(clk), .value(min_s), .root(root_w)
	);

	logic [NS+OUT_W-1:0] root_x;
	dist_t               out_q;
	always_comb begin
		root_x = (NS+OUT_W)'(root_w);
	end
	always_ff @(posedge clk) begin
		out_q <= (root_x > (NS+OUT_W)'(OUT_MAX)) ? OUT_MAX : root_x[OUT_W-1:0];
	end

	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	assign done = vld_q[LAT-1];
	assign distance_q = out_q;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching point");
	a_min_edge: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3+SW] |-> (min_s <= $past(e_ab) && min_s <= $past(e_bc) && min_s <= $past(e_ca)))
		else $error("nearest edge selection wrong");
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy && cfg_ready)
		else $error("block stalled a beat");

endmodule
`default_nettype wire
